[hw/rtl/cri_pkg.sv]
// ----------------------------------------------------------------------------
// cri_pkg: shared constants for the color ramp interpolator
// Field widths, operation codes and parameter defaults.
// ----------------------------------------------------------------------------
package cri_pkg;

  // Parameter defaults
  localparam int DEFAULT_RESOLUTION = 256;
  localparam int DEFAULT_MAX_POINTS = 16;

  // Field widths
  localparam int MODE_W = 2;
  localparam int IDX_W  = 8;
  localparam int CH_W   = 8;
  localparam int NUM_CH = 4;
  localparam int PT_W   = CH_W * NUM_CH;
  localparam int IN_W   = IDX_W + PT_W;

  // Width of the per-channel rounding numerator
  localparam int MIX_W  = 2 * CH_W;

  // Operation codes carried on in_tuser
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  // Status codes carried on out_tuser
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

endpackage

[hw/rtl/color_ramp_interpolator.sv]
// ----------------------------------------------------------------------------
// color_ramp_interpolator: linear gradient color lookup
// Holds a list of evenly spaced RGBA8 control points in a small memory and
// returns interpolated ramp entries, each channel rounded half up.
//
//   channel  dir  tdata (low bit first)              tuser
//   in_      in   entry_index, red, green, blue,     mode
//                 alpha (40 bits)
//   out_     out  red, green, blue, alpha (32 bits)  status
//
// Clear and append complete at accept. A query passes through the sequencer
// steps: index product at accept, then reciprocal divide, remainder fix,
// two-port point read, blend, reciprocal divide, rounding fix into the output
// register. A query on an empty list goes from accept straight to the rounding
// step.
// One item is in work at a time; a new one is taken once the last result
// sits in the output register. A stalled output holds the last stage only.
// Reset clears the point count; the point memory is not cleared.
// ----------------------------------------------------------------------------
module color_ramp_interpolator
  import cri_pkg::*;
#(
  parameter int RESOLUTION = DEFAULT_RESOLUTION,
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
  input  logic            clk,
  input  logic            rst_n,
  // in_tdata: entry_index[7:0], point_red[15:8], point_green[23:16],
  //           point_blue[31:24], point_alpha[39:32]
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  // in_tuser: mode[1:0]
  input  logic [MODE_W-1:0] in_tuser,
  // out_tdata: out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [PT_W-1:0] out_tdata,
  // out_tuser: status[0]
  output logic            out_tuser
);

  localparam int DEN = RESOLUTION - 1;
  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int NW  = IDX_W + AW;
  localparam logic [IDX_W-1:0] DEN_V   = IDX_W'(DEN);
  localparam logic [IDX_W-1:0] HALF_V  = IDX_W'(DEN / 2);
  localparam logic [NW:0]      RECIP_N = (NW + 1)'((2 ** NW) / DEN);
  localparam logic [MIX_W:0]   RECIP_C = (MIX_W + 1)'((2 ** MIX_W) / DEN);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_FIX  = 7'b0000100,
    S_RD   = 7'b0001000,
    S_MIX  = 7'b0010000,
    S_QT   = 7'b0100000,
    S_RND  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]    count_r, count_nxt;
  logic [PT_W-1:0]  point_mem [MAX_POINTS];

  logic [AW-1:0]    nm1_r;
  logic [NW-1:0]    num_r;
  logic [AW-1:0]    q0_r;
  logic [AW-1:0]    lo_r;
  logic [IDX_W-1:0] rem_r;
  logic             empty_r;
  logic [PT_W-1:0]  pa_r, pb_r;
  logic [MIX_W-1:0] w_r  [NUM_CH];
  logic [CH_W-1:0]  qc_r [NUM_CH];

  logic             out_valid_r;
  logic             out_status_r;
  logic [PT_W-1:0]  out_data_r;

  logic             in_acc;
  logic             out_free;
  logic [IDX_W-1:0] idx_c;
  logic [CW-1:0]    cnt_m1;
  logic [AW-1:0]    nm1_c;
  logic [NW-1:0]    num_c;
  logic [2*NW:0]    prod_n;
  logic [NW-1:0]    qd;
  logic [NW-1:0]    rem0;
  logic             rem_over;
  logic [AW-1:0]    hi_addr;
  logic [MIX_W-1:0] w_c  [NUM_CH];
  logic [2*MIX_W:0] prod_c [NUM_CH];
  logic [MIX_W-1:0] r0_c [NUM_CH];
  logic [PT_W-1:0]  color_c;

  // Handshake
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Clamp index and form index times (n-1)
  always_comb begin
    idx_c  = (in_tdata[IDX_W-1:0] > DEN_V) ? DEN_V : in_tdata[IDX_W-1:0];
    cnt_m1 = count_r - CW'(1);
    nm1_c  = cnt_m1[AW-1:0];
    num_c  = NW'(idx_c) * NW'(nm1_c);
  end

  // Reciprocal estimate of the lower point index, low by at most one
  assign prod_n = (2 * NW + 1)'(num_r) * (2 * NW + 1)'(RECIP_N);

  // Remainder check for the index estimate
  always_comb begin
    qd       = NW'(q0_r) * NW'(DEN_V);
    rem0     = num_r - qd;
    rem_over = (rem0 >= NW'(DEN_V));
  end

  // Upper neighbor saturates at the last point
  assign hi_addr = (lo_r == nm1_r) ? lo_r : lo_r + AW'(1);

  // Per-channel blend, reciprocal estimate and rounding fix
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      w_c[c] = MIX_W'(pa_r[c*CH_W +: CH_W]) * MIX_W'(DEN_V - rem_r)
             + MIX_W'(pb_r[c*CH_W +: CH_W]) * MIX_W'(rem_r)
             + MIX_W'(HALF_V);
      prod_c[c] = (2 * MIX_W + 1)'(w_r[c]) * (2 * MIX_W + 1)'(RECIP_C);
      r0_c[c]   = w_r[c] - MIX_W'(qc_r[c]) * MIX_W'(DEN_V);
      color_c[c*CH_W +: CH_W] = (r0_c[c] >= MIX_W'(DEN_V)) ? qc_r[c] + CH_W'(1)
                                                             : qc_r[c];
    end
  end

  // Sequencer and point count
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            MODE_CLEAR: count_nxt = '0;
            MODE_APPEND: begin
              if (count_r < CW'(MAX_POINTS)) begin
                count_nxt = count_r + CW'(1);
              end
            end
            MODE_QUERY: state_nxt = (count_r == '0) ? S_RND : S_DIV;
            default: ;
          endcase
        end
      end
      S_DIV: state_nxt = S_FIX;
      S_FIX: state_nxt = S_RD;
      S_RD:  state_nxt = S_MIX;
      S_MIX: state_nxt = S_QT;
      S_QT:  state_nxt = S_RND;
      S_RND: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Point memory: write on append, two registered reads; the sequencer
  // keeps writes and reads of one query apart
  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == MODE_APPEND) && (count_r < CW'(MAX_POINTS))) begin
      point_mem[count_r[AW-1:0]] <= in_tdata[IDX_W +: PT_W];
    end
    if (state_r == S_RD) begin
      pa_r <= point_mem[lo_r];
      pb_r <= point_mem[hi_addr];
    end
  end

  // Query datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      num_r   <= num_c;
      nm1_r   <= nm1_c;
      empty_r <= (count_r == '0);
    end
    if (state_r == S_DIV) begin
      q0_r <= prod_n[NW +: AW];
    end
    if (state_r == S_FIX) begin
      lo_r  <= rem_over ? q0_r + AW'(1) : q0_r;
      rem_r <= rem_over ? IDX_W'(rem0 - NW'(DEN_V)) : IDX_W'(rem0);
    end
    for (int c = 0; c < NUM_CH; c++) begin
      if (state_r == S_MIX) begin
        w_r[c] <= w_c[c];
      end
      if (state_r == S_QT) begin
        qc_r[c] <= prod_c[c][MIX_W +: CH_W];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_RND) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_RND) && out_free) begin
      out_status_r <= empty_r ? STATUS_EMPTY : STATUS_OK;
      out_data_r   <= empty_r ? '0 : color_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

`ifndef NO_ASSERTIONS
  // Point count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

  // Fixed index stays inside the list and remainder below the divisor
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> ((lo_r <= nm1_r) && (rem_r < DEN_V || DEN == 1)))
    else $error("interpolation index out of range");

  // Reciprocal estimate for channel 0 is never more than one low
  a_round_fix: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RND) && !empty_r) |->
      ((MIX_W + 1)'(r0_c[0]) < (MIX_W + 1)'(2 * DEN)))
    else $error("channel quotient estimate off by more than one");

  // A result appears only out of the rounding stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RND))
    else $error("result without a finished query");
`endif

endmodule

[verif/cri_ramp_checker.sv]
// ----------------------------------------------------------------------------
// cri_ramp_checker: scoreboard for the color ramp interpolator
// Watches the input and result streams and keeps its own copy of the point
// list. Each accepted query yields a predicted color. Each accepted result is
// compared, channel by channel, with the oldest predicted color.
// ----------------------------------------------------------------------------
module cri_ramp_checker
  import cri_pkg::*;
#(
  parameter int RESOLUTION = DEFAULT_RESOLUTION,
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  // in_tdata: entry_index, red, green, blue, alpha
  input  logic [IN_W-1:0]   in_tdata,
  // in_tuser: mode
  input  logic [MODE_W-1:0] in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  // out_tdata: red, green, blue, alpha
  input  logic [PT_W-1:0]   out_tdata,
  // out_tuser: status
  input  logic              out_tuser,
  output int                fail_count,
  output int                colors_pending,
  output int                colors_checked
);

  typedef struct packed {
    logic            status;
    logic [PT_W-1:0] rgba;
  } ramp_color_t;

  // Shadow copy of the point list
  logic [PT_W-1:0] point_mem [MAX_POINTS];
  int unsigned     point_total;

  ramp_color_t color_fifo [$];

  string chan_name [NUM_CH] = '{"red", "green", "blue", "alpha"};

  initial begin
    fail_count     = 0;
    colors_pending = 0;
    colors_checked = 0;
    point_total    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  // Interpolate ramp entry idx between its two neighboring control points
  function automatic ramp_color_t ramp_entry(input logic [IDX_W-1:0] idx);
    ramp_color_t   c;
    int unsigned   den, i, num, lo, hi, rem, a, b, acc;
    logic [PT_W-1:0] pa, pb;
    den = RESOLUTION - 1;
    c   = '0;
    if (point_total == 0) begin
      c.status = STATUS_EMPTY;
      return c;
    end
    i = 32'(idx);
    if (i > den) i = den;
    num = i * (point_total - 1);
    lo  = num / den;
    rem = num % den;
    hi  = (lo + 1 < point_total) ? lo + 1 : point_total - 1;
    if (lo >= point_total) lo = point_total - 1;
    pa = point_mem[lo];
    pb = point_mem[hi];
    c.status = STATUS_OK;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      a   = 32'(pa[ch*CH_W +: CH_W]);
      b   = 32'(pb[ch*CH_W +: CH_W]);
      acc = a * (den - rem) + b * rem;
      // round half up
      c.rgba[ch*CH_W +: CH_W] = CH_W'((2 * acc + den) / (2 * den));
    end
    return c;
  endfunction

  always @(posedge clk) begin
    ramp_color_t want;
    if (!rst_n) begin
      point_total = 0;
      color_fifo.delete();
      colors_pending <= 0;
    end else begin
      // Check one result transaction against the oldest prediction
      if (out_tvalid && out_tready) begin
        colors_checked++;
        if (color_fifo.size() == 0) begin
          report_mismatch($sformatf("result with no query pending: status=%0b data=%08h",
                                    out_tuser, out_tdata));
        end else begin
          want = color_fifo.pop_front();
          if (out_tuser !== want.status)
            report_mismatch($sformatf("status: got %0b want %0b", out_tuser, want.status));
          for (int ch = 0; ch < NUM_CH; ch++) begin
            if (out_tdata[ch*CH_W +: CH_W] !== want.rgba[ch*CH_W +: CH_W])
              report_mismatch($sformatf("%s: got %02h want %02h", chan_name[ch],
                                        out_tdata[ch*CH_W +: CH_W],
                                        want.rgba[ch*CH_W +: CH_W]));
          end
        end
      end
      // Advance the shadow point list on each input transaction
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          MODE_CLEAR: begin
            point_total = 0;
          end
          MODE_APPEND: begin
            if (point_total < MAX_POINTS) begin
              point_mem[point_total] = in_tdata[IN_W-1:IDX_W];
              point_total++;
            end
          end
          MODE_QUERY: begin
            color_fifo.push_back(ramp_entry(in_tdata[IDX_W-1:0]));
          end
          default: ;
        endcase
      end
      colors_pending <= color_fifo.size();
    end
  end

endmodule

[verif/tb_color_ramp_interpolator.sv]
// ----------------------------------------------------------------------------
// tb_color_ramp_interpolator: stimulus and verdict for the ramp interpolator
// Drives directed cases (empty list, single point, two extreme points, full
// list with a dropped append, ignored mode) and then random clear / append /
// query sequences with random stalls on both streams. A checker module
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_color_ramp_interpolator;
  import cri_pkg::*;

  localparam int RESOLUTION  = DEFAULT_RESOLUTION;
  localparam int MAX_POINTS  = DEFAULT_MAX_POINTS;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic [MODE_W-1:0] in_tuser = MODE_CLEAR;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [PT_W-1:0]   out_tdata;
  logic              out_tuser;

  int fail_count, colors_pending, colors_checked;
  int cycle_count = 0;
  int sent_clear = 0, sent_append = 0, sent_query = 0, sent_ignored = 0;
  bit burst = 1'b0;

  color_ramp_interpolator #(
    .RESOLUTION(RESOLUTION),
    .MAX_POINTS(MAX_POINTS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  cri_ramp_checker #(
    .RESOLUTION(RESOLUTION),
    .MAX_POINTS(MAX_POINTS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .colors_pending(colors_pending),
    .colors_checked(colors_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Guard against a hung handshake
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d colors still pending", cycle_count,
             colors_pending);
    $display("== FAIL ==");
    $finish;
  end

  // Mostly short idle gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: ready runs broken by random stalls
  initial begin
    int run_len, stall_len;
    wait (rst_n === 1'b1);
    forever begin
      out_tready <= 1'b1;
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
      repeat (run_len) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_tready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Send one input transaction, then idle for a random gap
  task automatic push_item(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                           input logic [PT_W-1:0] rgba);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {rgba, idx};
    do @(posedge clk); while (!in_tready);
    case (mode)
      MODE_CLEAR:  sent_clear++;
      MODE_APPEND: sent_append++;
      MODE_QUERY:  sent_query++;
      default:     sent_ignored++;
    endcase
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_append(input logic [PT_W-1:0] rgba);
    push_item(MODE_APPEND, IDX_W'($urandom()), rgba);
  endtask

  task automatic send_query(input logic [IDX_W-1:0] idx);
    push_item(MODE_QUERY, idx, $urandom());
  endtask

  // Hold off the sender until every predicted color has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (colors_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 8'd1;
      3:       return 8'd254;
      default: return IDX_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int counted, n_app, n_qry;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, ignored mode, single point
    send_query(8'd0);
    push_item(MODE_UNUSED, 8'hA5, 32'h5A5A_A5A5);
    send_append(32'hFF00_FF00);
    send_query(8'd255);
    // Directed: clear, then two extreme points and the ramp edges
    push_item(MODE_CLEAR, '1, '1);
    send_query(8'd77);
    send_append(32'h0000_0000);
    send_append(32'hFFFF_FFFF);
    send_query(8'd0);
    send_query(8'd127);
    send_query(8'd128);
    send_query(8'd255);
    // Directed: fill the list, one append past capacity is dropped
    for (int k = 0; k < MAX_POINTS - 1; k++) send_append($urandom());
    send_query(8'd255);
    drain_results();

    // Random sequences: mostly clear, fill, query
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) != 0) begin
        push_item(MODE_CLEAR, IDX_W'($urandom()), $urandom());
        counted++;
        if ($urandom_range(0, 9) == 0) begin
          send_query(pick_index());
          counted++;
        end
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: n_app = $urandom_range(1, 6);
        7, 8:                n_app = $urandom_range(7, MAX_POINTS);
        default:             n_app = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 4);
      endcase
      for (int k = 0; k < n_app; k++) begin
        send_append($urandom());
        counted++;
      end
      n_qry = $urandom_range(1, 12);
      for (int k = 0; k < n_qry; k++) begin
        case ($urandom_range(0, 19))
          0:       push_item(MODE_UNUSED, IDX_W'($urandom()), $urandom());
          1:       begin send_append($urandom()); counted++; end
          default: ;
        endcase
        send_query(pick_index());
        counted++;
      end
      if ($urandom_range(0, 24) == 0) drain_results();
    end

    // Drain and give the verdict
    in_tvalid <= 1'b0;
    do @(posedge clk); while (colors_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d clears, %0d appends, %0d queries and %0d ignored transactions",
             sent_clear, sent_append, sent_query, sent_ignored);
    $display("Checked %0d results against predicted ramp colors, %0d mismatches",
             colors_checked, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
